[sv/wpcs_pkg.sv]
// Package with shared constants, types and lookup tables for the white pixel steering unit.
`timescale 1ns / 1ps

package wpcs_pkg;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 10;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_WHITE_LEVEL   = 2'd0,
      CSR_CENTRE_COLUMN = 2'd1,
      CSR_TURN_SCALE    = 2'd2
   } csr_index_type;

   localparam logic [CSR_DATA_W-1:0] WHITE_LEVEL_RESET   = 10'd765;
   localparam logic [CSR_DATA_W-1:0] CENTRE_COLUMN_RESET = 10'd400;
   localparam logic [CSR_DATA_W-1:0] TURN_SCALE_RESET    = 10'd400;

   localparam logic [13:0]        SPEED_CAP   = 14'd13107;
   localparam logic signed [17:0] SPEED_FLOOR = -18'sd3277;
   localparam logic [16:0]        TURN_NEG_LIMIT = 17'd32768;
   localparam logic [16:0]        TURN_POS_LIMIT = 17'd32767;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_NORM,
      BK_PREP,
      BK_DIV,
      BK_ROUND,
      BK_DONE
   } back_state_type;

   // Octave value of 1.5655 * 2^(-0.233 e) in Q15.
   function automatic logic [15:0] oct_lookup(input logic [4:0] e);
      logic [15:0] v;
      case (e)
         5'd0:  v = 16'd51298;
         5'd1:  v = 16'd43648;
         5'd2:  v = 16'd37138;
         5'd3:  v = 16'd31600;
         5'd4:  v = 16'd26887;
         5'd5:  v = 16'd22877;
         5'd6:  v = 16'd19465;
         5'd7:  v = 16'd16562;
         5'd8:  v = 16'd14092;
         5'd9:  v = 16'd11991;
         5'd10: v = 16'd10202;
         5'd11: v = 16'd8681;
         5'd12: v = 16'd7386;
         5'd13: v = 16'd6285;
         5'd14: v = 16'd5347;
         5'd15: v = 16'd4550;
         5'd16: v = 16'd3871;
         5'd17: v = 16'd3294;
         5'd18: v = 16'd2803;
         5'd19: v = 16'd2385;
         5'd20: v = 16'd2029;
         5'd21: v = 16'd1726;
         5'd22: v = 16'd1469;
         5'd23: v = 16'd1250;
         5'd24: v = 16'd1064;
         5'd25: v = 16'd905;
         5'd26: v = 16'd770;
         5'd27: v = 16'd655;
         default: v = 16'd655;
      endcase
      return v;
   endfunction

   // Segment value of (1 + m/16)^-0.233 in Q16.
   function automatic logic [16:0] mant_lookup(input logic [3:0] m);
      logic [16:0] v;
      case (m)
         4'd0:  v = 17'd65536;
         4'd1:  v = 17'd64617;
         4'd2:  v = 17'd63762;
         4'd3:  v = 17'd62964;
         4'd4:  v = 17'd62216;
         4'd5:  v = 17'd61512;
         4'd6:  v = 17'd60849;
         4'd7:  v = 17'd60222;
         4'd8:  v = 17'd59628;
         4'd9:  v = 17'd59064;
         4'd10: v = 17'd58526;
         4'd11: v = 17'd58014;
         4'd12: v = 17'd57524;
         4'd13: v = 17'd57056;
         4'd14: v = 17'd56607;
         4'd15: v = 17'd56176;
         default: v = 17'd65536;
      endcase
      return v;
   endfunction

endpackage

[sv/wpcs_front.sv]
// Pixel front end: white classification and per-frame accumulation.
`timescale 1ns / 1ps

module wpcs_front #(
   parameter int COLUMN_BITS = 10,
   parameter int COUNT_BITS  = 21
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_red,
   input  logic [7:0]                        req_green,
   input  logic [7:0]                        req_blue,
   input  logic [COLUMN_BITS-1:0]            req_column,
   input  logic                              req_frame_end,
   input  logic [wpcs_pkg::CSR_DATA_W-1:0]   white_level,
   input  logic                              queue_full,
   output logic                              push,
   output logic [COUNT_BITS-1:0]             push_count,
   output logic [COLUMN_BITS+COUNT_BITS-1:0] push_sum
);

   localparam int SW = COLUMN_BITS + COUNT_BITS;

   logic [COUNT_BITS-1:0] white_total_ff, white_total_in;
   logic [SW-1:0]         column_total_ff, column_total_in;
   logic [9:0]            chan_sum;
   logic                  accept, is_white;
   logic [COUNT_BITS-1:0] count_next;
   logic [SW-1:0]         sum_next;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign chan_sum  = {2'b00, req_red} + {2'b00, req_green} + {2'b00, req_blue};
   // A saturated count stops both totals.
   assign is_white  = (chan_sum == white_level) && (white_total_ff != '1);

   assign count_next = white_total_ff + COUNT_BITS'(is_white);
   assign sum_next   = column_total_ff + (is_white ? SW'(req_column) : '0);

   assign push       = accept && req_frame_end;
   assign push_count = count_next;
   assign push_sum   = sum_next;

   always_comb begin
      white_total_in  = white_total_ff;
      column_total_in = column_total_ff;
      if (accept) begin
         if (req_frame_end) begin
            white_total_in  = '0;
            column_total_in = '0;
         end else begin
            white_total_in  = count_next;
            column_total_in = sum_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         white_total_ff  <= '0;
         column_total_ff <= '0;
      end else begin
         white_total_ff  <= white_total_in;
         column_total_ff <= column_total_in;
      end
   end

endmodule

[sv/wpcs_queue.sv]
// Two-entry queue of frame totals between the front end and the result engine.
`timescale 1ns / 1ps

module wpcs_queue #(
   parameter int WIDTH = 52
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[sv/wpcs_back.sv]
// Result engine: turn by long division, speed from the power table, output register.
`timescale 1ns / 1ps

module wpcs_back #(
   parameter int COLUMN_BITS = 10,
   parameter int COUNT_BITS  = 21
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              queue_empty,
   input  logic [COUNT_BITS-1:0]             queue_count,
   input  logic [COLUMN_BITS+COUNT_BITS-1:0] queue_sum,
   output logic                              pop,
   input  logic [wpcs_pkg::CSR_DATA_W-1:0]   centre_column,
   input  logic [wpcs_pkg::CSR_DATA_W-1:0]   turn_scale,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [15:0]                rsp_speed,
   output logic signed [15:0]                rsp_turn,
   output logic [COUNT_BITS-1:0]             rsp_white_count,
   output logic                              rsp_ball_seen
);

   localparam int SW   = COLUMN_BITS + COUNT_BITS;
   localparam int CW   = (COLUMN_BITS > 10) ? COLUMN_BITS : 10;
   localparam int MAGW = COUNT_BITS + CW;
   localparam int NW   = MAGW + 16;
   localparam int NSW  = COUNT_BITS + 10;
   localparam int DW   = NSW + 3;
   localparam int ITW  = $clog2(NW + 1);
   localparam int SHW  = $clog2(COUNT_BITS);

   wpcs_pkg::back_state_type state_ff, state_in;

   logic [COUNT_BITS-1:0] n_ff, n_in;
   logic [SW-1:0]         s_ff, s_in;
   logic [COUNT_BITS+9:0] cn_ff, cn_in;
   logic [NSW-1:0]        ns_ff, ns_in;
   logic [COUNT_BITS-1:0] norm_ff, norm_in;
   logic [SHW-1:0]        sh_ff, sh_in;
   logic                  neg_ff, neg_in;
   logic [DW-1:0]         den_ff, den_in;
   logic [DW-1:0]         rem_ff, rem_in;
   logic [NW-1:0]         quo_ff, quo_in;
   logic [ITW-1:0]        it_ff, it_in;
   logic [32:0]           pw_ff, pw_in;
   logic [13:0]           p_ff, p_in;
   logic [NW:0]           q_ff, q_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]    speed_ff, speed_in;
   logic signed [15:0]    turn_ff, turn_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  seen_ff, seen_in;

   logic [9:0]            scale_eff;
   logic [MAGW-1:0]       s_ext, cn_ext;
   logic [4:0]            e_val;
   logic [DW:0]           rem_sh;
   logic                  div_ge;
   logic                  round_up;
   logic [17:0]           p_round;
   logic [16:0]           turn_mag;
   logic [16:0]           half_mag;
   logic signed [17:0]    speed_full;
   logic                  out_free;

   assign scale_eff = (turn_scale == '0) ? 10'd1 : turn_scale;
   assign s_ext     = MAGW'(s_ff);
   assign cn_ext    = MAGW'(cn_ff);
   assign e_val     = 5'(COUNT_BITS - 1) - 5'(sh_ff);
   assign rem_sh    = {rem_ff, quo_ff[NW-1]};
   assign div_ge    = (rem_sh >= {1'b0, den_ff});
   // Round half away from zero: bump when twice the remainder reaches the divisor.
   assign round_up  = ({rem_ff, 1'b0} >= {1'b0, den_ff});
   assign p_round   = 18'(pw_ff + 33'd32768 >> 16);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (neg_ff) begin
         turn_mag = (q_ff > (NW+1)'(wpcs_pkg::TURN_NEG_LIMIT)) ?
                    wpcs_pkg::TURN_NEG_LIMIT : q_ff[16:0];
      end else begin
         turn_mag = (q_ff > (NW+1)'(wpcs_pkg::TURN_POS_LIMIT)) ?
                    wpcs_pkg::TURN_POS_LIMIT : q_ff[16:0];
      end
      half_mag   = 17'(({1'b0, turn_mag} + 18'd1) >> 1);
      speed_full = $signed({4'b0000, p_ff}) - $signed({1'b0, half_mag});
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wpcs_pkg::BK_IDLE: begin
            if (!queue_empty) begin
               state_in = wpcs_pkg::BK_MUL;
            end
         end
         wpcs_pkg::BK_MUL: begin
            state_in = (n_ff == '0) ? wpcs_pkg::BK_DONE : wpcs_pkg::BK_NORM;
         end
         wpcs_pkg::BK_NORM: begin
            if (norm_ff[COUNT_BITS-1]) begin
               state_in = wpcs_pkg::BK_PREP;
            end
         end
         wpcs_pkg::BK_PREP: state_in = wpcs_pkg::BK_DIV;
         wpcs_pkg::BK_DIV: begin
            if (it_ff == ITW'(1)) begin
               state_in = wpcs_pkg::BK_ROUND;
            end
         end
         wpcs_pkg::BK_ROUND: state_in = wpcs_pkg::BK_DONE;
         wpcs_pkg::BK_DONE: begin
            if (out_free) begin
               state_in = wpcs_pkg::BK_IDLE;
            end
         end
         default: state_in = wpcs_pkg::BK_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      pop          = 1'b0;
      n_in         = n_ff;
      s_in         = s_ff;
      cn_in        = cn_ff;
      ns_in        = ns_ff;
      norm_in      = norm_ff;
      sh_in        = sh_ff;
      neg_in       = neg_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      it_in        = it_ff;
      pw_in        = pw_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      speed_in     = speed_ff;
      turn_in      = turn_ff;
      count_in     = count_ff;
      seen_in      = seen_ff;
      case (state_ff)
         wpcs_pkg::BK_IDLE: begin
            if (!queue_empty) begin
               pop  = 1'b1;
               n_in = queue_count;
               s_in = queue_sum;
            end
         end
         wpcs_pkg::BK_MUL: begin
            cn_in   = (COUNT_BITS+10)'(centre_column * n_ff);
            ns_in   = NSW'(scale_eff * n_ff);
            norm_in = n_ff;
            sh_in   = '0;
         end
         wpcs_pkg::BK_NORM: begin
            if (!norm_ff[COUNT_BITS-1]) begin
               norm_in = norm_ff << 1;
               sh_in   = sh_ff + SHW'(1);
            end
         end
         wpcs_pkg::BK_PREP: begin
            if (s_ext > cn_ext) begin
               neg_in = 1'b1;
               quo_in = {s_ext - cn_ext, 16'd0};
            end else begin
               neg_in = 1'b0;
               quo_in = {cn_ext - s_ext, 16'd0};
            end
            den_in = {ns_ff, 2'b00} + DW'(ns_ff);
            rem_in = '0;
            it_in  = ITW'(NW);
            pw_in  = wpcs_pkg::oct_lookup(e_val) *
                     wpcs_pkg::mant_lookup(norm_ff[COUNT_BITS-2 -: 4]);
         end
         wpcs_pkg::BK_DIV: begin
            rem_in = div_ge ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
            quo_in = {quo_ff[NW-2:0], div_ge};
            it_in  = it_ff - ITW'(1);
         end
         wpcs_pkg::BK_ROUND: begin
            q_in = {1'b0, quo_ff} + (NW+1)'(round_up);
            p_in = (p_round > 18'(wpcs_pkg::SPEED_CAP)) ?
                   wpcs_pkg::SPEED_CAP : p_round[13:0];
         end
         wpcs_pkg::BK_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               count_in     = n_ff;
               if (n_ff == '0) begin
                  speed_in = '0;
                  turn_in  = '0;
                  seen_in  = 1'b0;
               end else begin
                  seen_in  = 1'b1;
                  turn_in  = neg_ff ? 16'(-{1'b0, turn_mag}) : 16'(turn_mag);
                  speed_in = (speed_full < wpcs_pkg::SPEED_FLOOR) ?
                             16'(wpcs_pkg::SPEED_FLOOR) : 16'(speed_full);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      s_ff     <= s_in;
      cn_ff    <= cn_in;
      ns_ff    <= ns_in;
      norm_ff  <= norm_in;
      sh_ff    <= sh_in;
      neg_ff   <= neg_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      it_ff    <= it_in;
      pw_ff    <= pw_in;
      p_ff     <= p_in;
      q_ff     <= q_in;
      speed_ff <= speed_in;
      turn_ff  <= turn_in;
      count_ff <= count_in;
      seen_ff  <= seen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wpcs_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_speed       = speed_ff;
   assign rsp_turn        = turn_ff;
   assign rsp_white_count = count_ff;
   assign rsp_ball_seen   = seen_ff;

endmodule

[sv/white_pixel_centroid_steering_unit.sv]
// Top level of the white pixel centroid steering unit.
`timescale 1ns / 1ps

// Pixels are taken one per clock cycle with no gaps while the queue of finished frames has
// room; every pixel stalls while two finished frames already wait for the result engine.
// Each frame end yields one speed and turn result. Unless the white count is zero, the turn
// comes from a long division that produces one quotient bit per cycle, preceded by a
// leading-one search over the white count that shifts one bit per cycle. Register writes
// take effect at once and are meant for idle periods.

module white_pixel_centroid_steering_unit #(
   parameter int COLUMN_BITS = 10,
   parameter int COUNT_BITS  = 21
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_red,
   input  logic [7:0]                      req_green,
   input  logic [7:0]                      req_blue,
   input  logic [COLUMN_BITS-1:0]          req_column,
   input  logic                            req_frame_end,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [15:0]              rsp_speed,
   output logic signed [15:0]              rsp_turn,
   output logic [COUNT_BITS-1:0]           rsp_white_count,
   output logic                            rsp_ball_seen,
   input  logic                            csr_we,
   input  logic [wpcs_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [wpcs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int SW = COLUMN_BITS + COUNT_BITS;

   logic [wpcs_pkg::CSR_DATA_W-1:0] white_level_ff, white_level_in;
   logic [wpcs_pkg::CSR_DATA_W-1:0] centre_column_ff, centre_column_in;
   logic [wpcs_pkg::CSR_DATA_W-1:0] turn_scale_ff, turn_scale_in;

   logic                  push, pop, queue_full, queue_empty;
   logic [COUNT_BITS-1:0] push_count;
   logic [SW-1:0]         push_sum;
   logic [SW+COUNT_BITS-1:0] pop_data;

   always_comb begin
      white_level_in   = white_level_ff;
      centre_column_in = centre_column_ff;
      turn_scale_in    = turn_scale_ff;
      if (csr_we) begin
         case (csr_addr)
            wpcs_pkg::CSR_WHITE_LEVEL:   white_level_in   = csr_wdata;
            wpcs_pkg::CSR_CENTRE_COLUMN: centre_column_in = csr_wdata;
            wpcs_pkg::CSR_TURN_SCALE:    turn_scale_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         white_level_ff   <= wpcs_pkg::WHITE_LEVEL_RESET;
         centre_column_ff <= wpcs_pkg::CENTRE_COLUMN_RESET;
         turn_scale_ff    <= wpcs_pkg::TURN_SCALE_RESET;
      end else begin
         white_level_ff   <= white_level_in;
         centre_column_ff <= centre_column_in;
         turn_scale_ff    <= turn_scale_in;
      end
   end

   wpcs_front #(
      .COLUMN_BITS(COLUMN_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_red      (req_red),
      .req_green    (req_green),
      .req_blue     (req_blue),
      .req_column   (req_column),
      .req_frame_end(req_frame_end),
      .white_level  (white_level_ff),
      .queue_full   (queue_full),
      .push         (push),
      .push_count   (push_count),
      .push_sum     (push_sum)
   );

   wpcs_queue #(
      .WIDTH(SW + COUNT_BITS)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data({push_count, push_sum}),
      .pop      (pop),
      .pop_data (pop_data),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   wpcs_back #(
      .COLUMN_BITS(COLUMN_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .queue_count    (pop_data[SW+COUNT_BITS-1:SW]),
      .queue_sum      (pop_data[SW-1:0]),
      .pop            (pop),
      .centre_column  (centre_column_ff),
      .turn_scale     (turn_scale_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_speed      (rsp_speed),
      .rsp_turn       (rsp_turn),
      .rsp_white_count(rsp_white_count),
      .rsp_ball_seen  (rsp_ball_seen)
   );

endmodule
